// ===== hw/rtl/abnal_pkg.sv =====
// Shared types and constants for the Annex-B to length-prefixed NAL splitter.
// Holds the channel item structs, the result kind codes and the per-item plan.
// No dependencies.
package abnal_pkg;

  // Width of the saturating length counters.
  localparam int COUNT_BITS = 24;
  // Width of the length fields on the result channel.
  localparam int LEN_W = 24;
  // Each NAL gets a four byte length prefix downstream.
  localparam int PREFIX_BYTES = 4;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  typedef logic [COUNT_BITS-1:0] cnt_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_NAL_END   = 2'd1,
    KIND_UNIT_DONE = 2'd2,
    KIND_NO_CODE   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_of_unit;
  } in_item_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       payload_byte;
    logic [LEN_W-1:0] nal_length;
    logic [LEN_W-1:0] unit_total;
    logic             last;
  } out_item_t;

  // Everything one input item produces, in emission order: zero bytes,
  // then one data byte, then a NAL end record, then a unit-level record.
  typedef struct packed {
    logic [2:0] zeros;
    logic       byte_pend;
    logic [7:0] byte_val;
    logic       end_pend;
    cnt_t       nal_len;
    cnt_t       len4;
    logic       fin_pend;
    logic       fin_err;
  } plan_t;

endpackage

// ===== hw/rtl/annexb_to_length_prefixed_nal.sv =====
// Top level of the Annex-B to length-prefixed NAL splitter.
// Depends on abnal_pkg, abnal_split and abnal_emit.
//
// Usage: the input channel carries one byte of an H.264 access unit per item,
// with last_of_unit set on the unit's final byte. Bytes before the first start
// code are dropped. Start codes 00 00 01 and 00 00 00 01 split the unit into
// NALs; payload bytes come out as kind 0 items, each NAL closes with a kind 1
// item that carries its length, and the unit closes with a kind 2 item giving
// the size the unit takes once every NAL has a four byte length prefix, or a
// kind 3 item if no start code was seen. The out last bit marks the final
// result caused by one input byte. Lengths saturate at the counter maximum.
// Results for a byte appear in the cycle after it is accepted. Unless the
// receiver stalls, a byte that yields at most one result is followed by the
// next byte in the very next cycle. A byte that yields more (up to six, at
// a start code or a unit end) holds the input off until its last result is
// taken, as the result register hands out one result per unstalled cycle;
// the next byte is taken in the same cycle as the last of those results.
// When the receiver stalls, the current result holds and the input stalls
// unless the pending register is empty. Reset clears the parser state, the
// running total and any pending results; the block takes a byte right after.
module annexb_to_length_prefixed_nal (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  abnal_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output abnal_pkg::out_item_t out_item
);

  abnal_pkg::plan_t plan;
  logic             has_results;
  logic             room;
  logic             in_take;

  // The input waits only while the result register still has results that
  // will not all be gone at this edge.
  assign in_stall = !room;
  assign in_take  = in_valid && room;

  abnal_split u_split (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (in_take),
    .item        (in_item),
    .plan        (plan),
    .has_results (has_results)
  );

  // Bytes that only update parser state (held zeros, search) load nothing.
  abnal_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_take && has_results),
    .plan_in   (plan),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== hw/rtl/abnal_split.sv =====
// Start code parser: tracks search state, held zeros and the NAL byte count,
// and turns each accepted byte into a plan of results.
// Depends on abnal_pkg.
module abnal_split (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  abnal_pkg::in_item_t item,
  output abnal_pkg::plan_t    plan,
  output logic               has_results
);

  logic             inside_r, inside_nxt;
  logic [1:0]       zrun_r, zrun_nxt;
  logic [1:0]       held_r, held_nxt;
  abnal_pkg::cnt_t  rc_r, rc_nxt;

  logic             code;
  logic [2:0]       zeros;
  logic             byte_f, end_f, fin_f, fin_err;
  logic [2:0]       inc;
  logic [abnal_pkg::COUNT_BITS:0] sum_len, sum_len4;
  abnal_pkg::cnt_t  nal_len, len4;

  always_comb begin
    inside_nxt = inside_r;
    zrun_nxt   = zrun_r;
    held_nxt   = held_r;
    code       = 1'b0;
    zeros      = 3'd0;
    byte_f     = 1'b0;
    end_f      = 1'b0;
    fin_f      = 1'b0;
    fin_err    = 1'b0;
    if (!inside_r) begin
      if (item.data_byte == 8'd1 && zrun_r >= 2'd2) begin
        inside_nxt = 1'b1;
        zrun_nxt   = 2'd0;
      end else if (item.data_byte == 8'd0) begin
        if (zrun_r != 2'd3) begin
          zrun_nxt = zrun_r + 2'd1;
        end
      end else begin
        zrun_nxt = 2'd0;
      end
      if (item.last_of_unit) begin
        fin_f   = 1'b1;
        fin_err = !inside_nxt;
      end
    end else begin
      if (item.data_byte == 8'd0) begin
        // Only the three newest zeros can start a code; an older one is payload.
        if (held_r == 2'd3) begin
          zeros = 3'd1;
        end else begin
          held_nxt = held_r + 2'd1;
        end
      end else if (item.data_byte == 8'd1 && held_r >= 2'd2) begin
        code     = 1'b1;
        held_nxt = 2'd0;
        end_f    = 1'b1;
      end else begin
        zeros    = {1'b0, held_r};
        byte_f   = 1'b1;
        held_nxt = 2'd0;
      end
      if (item.last_of_unit) begin
        fin_f = 1'b1;
        if (!code) begin
          zeros = zeros + {1'b0, held_nxt};
          end_f = 1'b1;
        end
      end
    end
  end

  assign inc      = zeros + {2'b00, byte_f};
  assign sum_len  = {1'b0, rc_r} + (abnal_pkg::COUNT_BITS+1)'(inc);
  assign sum_len4 = {1'b0, rc_r} + (abnal_pkg::COUNT_BITS+1)'(inc)
                  + (abnal_pkg::COUNT_BITS+1)'(abnal_pkg::PREFIX_BYTES);
  assign nal_len  = sum_len[abnal_pkg::COUNT_BITS] ? abnal_pkg::CNT_MAX
                                                   : sum_len[abnal_pkg::COUNT_BITS-1:0];
  assign len4     = sum_len4[abnal_pkg::COUNT_BITS] ? abnal_pkg::CNT_MAX
                                                    : sum_len4[abnal_pkg::COUNT_BITS-1:0];

  assign rc_nxt = (end_f || item.last_of_unit) ? '0 : nal_len;

  always_comb begin
    plan.zeros     = zeros;
    plan.byte_pend = byte_f;
    plan.byte_val  = item.data_byte;
    plan.end_pend  = end_f;
    plan.nal_len   = nal_len;
    plan.len4      = len4;
    plan.fin_pend  = fin_f;
    plan.fin_err   = fin_err;
  end

  assign has_results = (zeros != 3'd0) || byte_f || end_f || fin_f;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
      zrun_r   <= 2'd0;
      held_r   <= 2'd0;
      rc_r     <= '0;
    end else if (take) begin
      if (item.last_of_unit) begin
        inside_r <= 1'b0;
        zrun_r   <= 2'd0;
        held_r   <= 2'd0;
      end else begin
        inside_r <= inside_nxt;
        zrun_r   <= zrun_nxt;
        held_r   <= held_nxt;
      end
      rc_r <= rc_nxt;
    end
  end

endmodule

// ===== hw/rtl/abnal_emit.sv =====
// Result sequencer (depends on abnal_pkg): holds one item's plan and hands
// out results one per unstalled cycle, keeping the unit's running prefixed size.
module abnal_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  abnal_pkg::plan_t     plan_in,
  output logic                room,
  output logic                out_valid,
  input  logic                out_stall,
  output abnal_pkg::out_item_t out_item
);

  abnal_pkg::plan_t plan_r, plan_nxt;
  abnal_pkg::cnt_t  acc_r, acc_nxt;
  logic [abnal_pkg::COUNT_BITS:0] acc_sum;
  logic [2:0]       remaining;
  logic             is_last, take;

  assign remaining = plan_r.zeros + {2'b00, plan_r.byte_pend}
                   + {2'b00, plan_r.end_pend} + {2'b00, plan_r.fin_pend};
  assign out_valid = remaining != 3'd0;
  assign is_last   = remaining == 3'd1;
  assign take      = out_valid && !out_stall;
  assign room      = !out_valid || (take && is_last);
  assign acc_sum   = {1'b0, acc_r} + {1'b0, plan_r.len4};

  always_comb begin
    out_item.kind         = abnal_pkg::KIND_PAYLOAD;
    out_item.payload_byte = 8'd0;
    out_item.nal_length   = '0;
    out_item.unit_total   = '0;
    out_item.last         = is_last;
    priority if (plan_r.zeros != 3'd0) begin
      out_item.kind = abnal_pkg::KIND_PAYLOAD;
    end else if (plan_r.byte_pend) begin
      out_item.payload_byte = plan_r.byte_val;
    end else if (plan_r.end_pend) begin
      out_item.kind       = abnal_pkg::KIND_NAL_END;
      out_item.nal_length = abnal_pkg::LEN_W'(plan_r.nal_len);
    end else if (plan_r.fin_err) begin
      out_item.kind = abnal_pkg::KIND_NO_CODE;
    end else begin
      out_item.kind       = abnal_pkg::KIND_UNIT_DONE;
      out_item.unit_total = abnal_pkg::LEN_W'(acc_r);
    end
  end

  always_comb begin
    plan_nxt = plan_r;
    acc_nxt  = acc_r;
    if (take) begin
      priority if (plan_r.zeros != 3'd0) begin
        plan_nxt.zeros = plan_r.zeros - 3'd1;
      end else if (plan_r.byte_pend) begin
        plan_nxt.byte_pend = 1'b0;
      end else if (plan_r.end_pend) begin
        plan_nxt.end_pend = 1'b0;
        acc_nxt = acc_sum[abnal_pkg::COUNT_BITS] ? abnal_pkg::CNT_MAX
                                                 : acc_sum[abnal_pkg::COUNT_BITS-1:0];
      end else begin
        plan_nxt.fin_pend = 1'b0;
        acc_nxt           = '0;
      end
    end
    if (load) begin
      plan_nxt = plan_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plan_r <= '0;
      acc_r  <= '0;
    end else begin
      plan_r <= plan_nxt;
      acc_r  <= acc_nxt;
    end
  end

endmodule

// ===== verif/tb_annexb_to_length_prefixed_nal.sv =====
// Self-checking testbench for annexb_to_length_prefixed_nal.
// Feeds Annex-B access units byte by byte and checks every result record against
// a local predictor of the NAL splitter. Depends on abnal_pkg and the RTL only.
module tb_annexb_to_length_prefixed_nal;

  // Generous watchdog.
  localparam int CYCLE_LIMIT  = 200000;
  // Cycles allowed after the last expected record, and the length of the hold.
  localparam int DRAIN_CYCLES = 20;
  localparam int LONG_HOLD    = 150;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  abnal_pkg::in_item_t  in_item;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  abnal_pkg::out_item_t out_item;

  annexb_to_length_prefixed_nal uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always #5 clk = ~clk;

  // Records that the splitter must still deliver, oldest first.
  abnal_pkg::out_item_t records_due[$];

  // Predictor state: a mirror of the splitter's parser.
  logic            seen_code;    // first start code of the unit found
  logic [1:0]      lead_zeros;   // zeros in a row while the first code is sought
  logic [1:0]      held_zeros;   // zeros held back because they may open a code
  abnal_pkg::cnt_t nal_len;      // payload bytes of the open NAL so far
  abnal_pkg::cnt_t unit_total;   // prefixed size of the NALs that have closed

  // Knobs shared by the sender, the receiver and the tests.
  logic send_idle_on;
  logic stall_idle_on;
  int   hold_request = 0;
  int   hold_left    = 0;

  // Bookkeeping for the checks and the closing summary.
  int mismatches      = 0;
  int results_checked = 0;
  int nal_ends_seen   = 0;
  int units_done_seen = 0;
  int no_code_seen    = 0;
  int bytes_sent      = 0;
  int units_sent      = 0;
  int cycle_count     = 0;
  int in_stall_cycles = 0;

  abnal_pkg::out_item_t due_rec;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic abnal_pkg::cnt_t sat_add(input abnal_pkg::cnt_t a,
                                              input abnal_pkg::cnt_t b);
    logic [abnal_pkg::COUNT_BITS:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[abnal_pkg::COUNT_BITS] ? abnal_pkg::CNT_MAX
                                      : sum[abnal_pkg::COUNT_BITS-1:0];
  endfunction

  function automatic abnal_pkg::out_item_t make_rec(input abnal_pkg::kind_t k,
                                                    input logic [7:0] pb,
                                                    input abnal_pkg::cnt_t len,
                                                    input abnal_pkg::cnt_t tot);
    abnal_pkg::out_item_t r;
    r.kind         = k;
    r.payload_byte = pb;
    r.nal_length   = len[abnal_pkg::LEN_W-1:0];
    r.unit_total   = tot[abnal_pkg::LEN_W-1:0];
    r.last         = 1'b0;
    return r;
  endfunction

  task automatic clear_split_state();
    seen_code  = 1'b0;
    lead_zeros = '0;
    held_zeros = '0;
    nal_len    = '0;
    unit_total = '0;
  endtask

  task automatic emit_payload(ref abnal_pkg::out_item_t recs[$], input logic [7:0] b);
    recs.push_back(make_rec(abnal_pkg::KIND_PAYLOAD, b, '0, '0));
    nal_len = sat_add(nal_len, abnal_pkg::cnt_t'(1));
  endtask

  // Held-back zeros turn out not to open a code: they belong to the NAL.
  task automatic flush_held(ref abnal_pkg::out_item_t recs[$]);
    repeat (held_zeros) emit_payload(recs, 8'h00);
    held_zeros = '0;
  endtask

  task automatic close_nal(ref abnal_pkg::out_item_t recs[$]);
    recs.push_back(make_rec(abnal_pkg::KIND_NAL_END, 8'h00, nal_len, '0));
    unit_total = sat_add(unit_total,
                         sat_add(abnal_pkg::cnt_t'(abnal_pkg::PREFIX_BYTES), nal_len));
    nal_len    = '0;
  endtask

  // Works out every record one accepted byte causes and queues them.
  task automatic split_annexb_byte(input logic [7:0] b, input logic lst);
    abnal_pkg::out_item_t recs[$];
    logic                 at_code;
    at_code = 1'b0;
    if (!seen_code) begin
      // Still hunting for the first start code; everything here is dropped.
      if (b == 8'h01 && lead_zeros >= 2) begin
        seen_code  = 1'b1;
        lead_zeros = '0;
      end else if (b == 8'h00) begin
        if (lead_zeros < 3) lead_zeros++;
      end else begin
        lead_zeros = '0;
      end
      if (lst) begin
        if (seen_code)
          recs.push_back(make_rec(abnal_pkg::KIND_UNIT_DONE, 8'h00, '0, unit_total));
        else recs.push_back(make_rec(abnal_pkg::KIND_NO_CODE, 8'h00, '0, '0));
        clear_split_state();
      end
    end else begin
      if (b == 8'h00) begin
        // Only the last three zeros can be part of a code; older ones spill.
        if (held_zeros == 2'd3) begin
          emit_payload(recs, 8'h00);
          held_zeros = 2'd2;
        end
        held_zeros++;
      end else if (b == 8'h01 && held_zeros >= 2) begin
        // Three or four byte code: the held zeros are swallowed.
        at_code    = 1'b1;
        held_zeros = '0;
        close_nal(recs);
      end else begin
        flush_held(recs);
        emit_payload(recs, b);
      end
      if (lst) begin
        // A code on the last byte leaves no final NAL behind it.
        if (!at_code) begin
          flush_held(recs);
          close_nal(recs);
        end
        recs.push_back(make_rec(abnal_pkg::KIND_UNIT_DONE, 8'h00, '0, unit_total));
        clear_split_state();
      end
    end
    if (recs.size() > 0) recs[recs.size()-1].last = 1'b1;
    foreach (recs[i]) records_due.push_back(recs[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offers one byte and returns at the edge that accepts it. Valid stays high
  // on return so that the next byte can follow without a bubble.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    abnal_pkg::in_item_t it;
    it.data_byte    = b;
    it.last_of_unit = lst;
    while (send_idle_on && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    split_annexb_byte(b, lst);
    bytes_sent++;
  endtask

  // Sends a whole access unit with the last-of-unit flag on its final byte.
  task automatic send_unit(input logic [7:0] u[$]);
    foreach (u[i]) send_byte(u[i], i == u.size() - 1);
    units_sent++;
  endtask

  // Drops valid and waits until the splitter has delivered everything.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (records_due.size() != 0) @(posedge clk);
  endtask

  // Payload bytes lean toward 00 and 01 so that codes and near-codes are common.
  function automatic logic [7:0] rand_payload_byte();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) return 8'h00;
    else if (pick == 3) return 8'h01;
    else if (pick == 4) return 8'hFF;
    else return 8'($urandom_range(0, 255));
  endfunction

  // A well-formed unit: optional junk, then one to four NALs each behind a
  // three or four byte code, sometimes with one or two extra zeros ahead of it.
  task automatic make_random_unit(output logic [7:0] u[$]);
    int n_nals;
    int plen;
    u = {};
    repeat ($urandom_range(0, 2)) u.push_back(8'($urandom_range(0, 255)));
    n_nals = $urandom_range(1, 4);
    repeat (n_nals) begin
      if ($urandom_range(0, 3) == 0) u.push_back(8'h00);
      if ($urandom_range(0, 7) == 0) u.push_back(8'h00);
      u.push_back(8'h00);
      u.push_back(8'h00);
      u.push_back(8'h01);
      plen = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
      repeat (plen) u.push_back(rand_payload_byte());
    end
  endtask

  // Noise: short units made mostly of zeros and ones, so codes appear only by
  // chance, often broken off or never completed.
  task automatic make_noise_unit(output logic [7:0] u[$]);
    int pick;
    u = {};
    repeat ($urandom_range(1, 10)) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) u.push_back(8'h00);
      else if (pick < 8) u.push_back(8'h01);
      else u.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random stalls, plus a long hold when a test asks for one.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= stall_idle_on && ($urandom_range(0, 99) < 8);
    end
  end

  task automatic check_field(input string fname, input logic [23:0] want,
                             input logic [23:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch on result %0d, expected %0h, got %0h",
               $time, fname, results_checked, want, got);
    end
  endtask

  // Outputs only move at the rising edge, so the falling edge sees exactly the
  // handshake that the next rising edge will complete.
  always @(negedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (records_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got kind %0h byte %0h len %0h tot %0h",
                 $time, out_item.kind, out_item.payload_byte, out_item.nal_length,
                 out_item.unit_total);
      end else begin
        due_rec = records_due.pop_front();
        check_field("kind", 24'(due_rec.kind), 24'(out_item.kind));
        check_field("payload_byte", 24'(due_rec.payload_byte), 24'(out_item.payload_byte));
        check_field("nal_length", due_rec.nal_length, out_item.nal_length);
        check_field("unit_total", due_rec.unit_total, out_item.unit_total);
        check_field("last", 24'(due_rec.last), 24'(out_item.last));
        case (due_rec.kind)
          abnal_pkg::KIND_NAL_END:   nal_ends_seen++;
          abnal_pkg::KIND_UNIT_DONE: units_done_seen++;
          abnal_pkg::KIND_NO_CODE:   no_code_seen++;
          default: ;
        endcase
      end
      results_checked++;
    end
  end

  // Watchdog; also counts the cycles in which the splitter pushed back.
  always @(posedge clk) begin
    cycle_count++;
    if (in_valid && in_stall) in_stall_cycles++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d records outstanding",
               cycle_count, records_due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // A unit with no start code at all must give the error record.
  task automatic test_no_start_code();
    send_unit('{8'hFF});
  endtask

  // A unit that is nothing but a start code ends on its last byte with a
  // total of zero and no NAL end record.
  task automatic test_code_only_unit();
    send_unit('{8'h00, 8'h00, 8'h01});
  endtask

  // Junk ahead of a four byte code is dropped, and a zero held at the end of
  // the unit is payload of the final NAL.
  task automatic test_four_byte_code();
    send_unit('{8'h7E, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h00});
  endtask

  // An empty NAL between two codes, then five zeros before a code so that
  // two of them spill out as payload, and a code on the unit's last byte.
  task automatic test_empty_nal_and_zero_overflow();
    send_unit('{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01,
                8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01});
  endtask

  task automatic test_random_units();
    logic [7:0] u[$];
    int stop_at;
    stop_at = bytes_sent + 80;
    while (bytes_sent < stop_at) begin
      make_random_unit(u);
      send_unit(u);
    end
  endtask

  task automatic test_noise_units();
    logic [7:0] u[$];
    int stop_at;
    stop_at = bytes_sent + 30;
    while (bytes_sent < stop_at) begin
      make_noise_unit(u);
      send_unit(u);
    end
  endtask

  // No gaps on either side, so the block runs at its full byte rate.
  task automatic test_back_to_back();
    logic [7:0] u[$];
    int stop_at;
    send_idle_on  = 1'b0;
    stall_idle_on = 1'b0;
    stop_at = bytes_sent + 25;
    while (bytes_sent < stop_at) begin
      make_random_unit(u);
      send_unit(u);
    end
    send_idle_on  = 1'b1;
    stall_idle_on = 1'b1;
  endtask

  // The receiver holds off for a long time while bytes keep coming, so the
  // splitter fills up and must stall its input. Afterwards the sender pauses
  // until every record has come out.
  task automatic test_receiver_hold();
    logic [7:0] u[$];
    int stop_at;
    send_idle_on = 1'b0;
    hold_request = LONG_HOLD;
    stop_at = bytes_sent + 20;
    while (bytes_sent < stop_at) begin
      make_random_unit(u);
      send_unit(u);
    end
    wait_for_drain();
    send_idle_on = 1'b1;
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_item       <= '0;
    send_idle_on  = 1'b1;
    stall_idle_on = 1'b1;
    clear_split_state();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_no_start_code();
    test_code_only_unit();
    test_four_byte_code();
    test_empty_nal_and_zero_overflow();
    test_random_units();
    test_noise_units();
    test_back_to_back();
    test_receiver_hold();

    // Everything offered has been taken; let the last records drain and make
    // sure nothing extra trails behind them.
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (records_due.size() != 0) begin
      mismatches++;
      $display("%0t: outstanding records, expected 0, got %0d", $time, records_due.size());
    end

    $display("Sent %0d bytes in %0d access units; checked %0d results, %0d NAL ends,",
             bytes_sent, units_sent, results_checked, nal_ends_seen);
    $display("%0d finished units and %0d units without a start code; input stalled %0d cycles.",
             units_done_seen, no_code_seen, in_stall_cycles);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/abnal_pkg.sv
hw/rtl/abnal_split.sv
hw/rtl/abnal_emit.sv
hw/rtl/annexb_to_length_prefixed_nal.sv
verif/tb_annexb_to_length_prefixed_nal.sv
